// ----- rtl/irrc_pkg.sv -----
// irrc_pkg: shared types and fixed constants for the ir remote command sampler
// no dependencies; imported by irrc_decoder and ir_remote_command_sampler
`timescale 1ns / 1ps

package irrc_pkg;

   // fixed widths of the register and the result fields
   localparam int unsigned PERIOD_WIDTH  = 16;
   localparam int unsigned DIGIT_WIDTH   = 4;

   // register reset value and the largest accepted command digit
   localparam logic [PERIOD_WIDTH-1:0] SAMPLE_PERIOD_RESET = 16'd51000;
   localparam logic [7:0]              COMMAND_MAX         = 8'd9;

   // one result word
   typedef struct packed {
      logic                   command_strobe;
      logic [DIGIT_WIDTH-1:0] command;
      logic                   command_valid;
   } result_type;

endpackage

// ----- rtl/irrc_decoder.sv -----
// irrc_decoder: edge detect, start framing and bit sampling state machine
// depends on irrc_pkg for the result type and constants
`timescale 1ns / 1ps

module irrc_decoder #(
   parameter int unsigned SAMPLE_COUNT = 12,
   parameter int unsigned COMMAND_BITS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              pin_level,
   input  logic [irrc_pkg::PERIOD_WIDTH-1:0] sample_period,
   output irrc_pkg::result_type              result
);
   import irrc_pkg::*;

   localparam logic [1:0] MODE_IDLE     = 2'd0;
   localparam logic [1:0] MODE_MEASURE  = 2'd1;
   localparam logic [1:0] MODE_ARMED    = 2'd2;
   localparam logic [1:0] MODE_SAMPLING = 2'd3;

   localparam logic [3:0] LAST_SAMPLE = 4'(SAMPLE_COUNT);

   logic [1:0]              mode_ff, mode_in;
   logic                    prev_level_ff;
   logic [PERIOD_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [3:0]              samples_ff, samples_in;
   logic [COMMAND_BITS-1:0] bits_ff, bits_in;
   logic [DIGIT_WIDTH-1:0]  command_ff, command_in;
   logic                    have_ff, have_in;
   logic                    strobe;
   logic                    edge_seen;
   logic [7:0]              bits_ext;

   assign edge_seen = pin_level != prev_level_ff;
   assign bits_ext  = 8'(bits_ff);

   // next state for one pin word
   always_comb begin
      mode_in       = mode_ff;
      tick_count_in = tick_count_ff;
      samples_in    = samples_ff;
      bits_in       = bits_ff;
      command_in    = command_ff;
      have_in       = have_ff;
      strobe        = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (edge_seen && !pin_level) mode_in = MODE_MEASURE;
         end
         MODE_MEASURE: begin
            if (edge_seen) mode_in = MODE_ARMED;
         end
         MODE_ARMED: begin
            if (edge_seen) begin
               mode_in       = MODE_SAMPLING;
               tick_count_in = '0;
               samples_in    = '0;
               bits_in       = '0;
            end
         end
         default: begin
            if (tick_count_ff >= sample_period) begin
               tick_count_in = '0;
               if (samples_ff < LAST_SAMPLE) begin
                  // inverted pin shifts in at the bottom; only the last COMMAND_BITS samples are kept, earliest on top
                  bits_in    = COMMAND_BITS'({bits_ff, ~pin_level});
                  samples_in = samples_ff + 4'd1;
               end else begin
                  if (bits_ext <= COMMAND_MAX) begin
                     command_in = bits_ext[DIGIT_WIDTH-1:0];
                     have_in    = 1'b1;
                     strobe     = 1'b1;
                  end
                  mode_in    = MODE_IDLE;
                  samples_in = '0;
                  bits_in    = '0;
               end
            end else begin
               tick_count_in = tick_count_ff + 1'b1;
            end
         end
      endcase
   end

   // result for the word being accepted
   always_comb begin
      result.command_valid  = have_in;
      result.command        = command_in;
      result.command_strobe = strobe;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         prev_level_ff <= 1'b1;
         tick_count_ff <= '0;
         samples_ff    <= '0;
         bits_ff       <= '0;
         command_ff    <= '0;
         have_ff       <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         prev_level_ff <= pin_level;
         tick_count_ff <= tick_count_in;
         samples_ff    <= samples_in;
         bits_ff       <= bits_in;
         command_ff    <= command_in;
         have_ff       <= have_in;
      end
   end

endmodule

// ----- rtl/ir_remote_command_sampler.sv -----
// ir_remote_command_sampler: top level with config register and output skid stage
// depends on irrc_pkg and irrc_decoder
`timescale 1ns / 1ps

// One pin word is taken per clock while req_tready is high; each gives
// exactly one registered result. The decoder state is updated in a single
// pass of logic per word, so a word can be accepted on every cycle. When
// the result side stalls, the output register and a one-word skid stage
// absorb up to two results; req_tready drops only while the skid stage is
// full. sample_period may be written only while no results are pending.
module ir_remote_command_sampler #(
   parameter int unsigned SAMPLE_COUNT = 12,
   parameter int unsigned COMMAND_BITS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [0] pin_level, [7:1] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] command_valid, [4:1] command, [5] command_strobe, [7:6] zero
   output logic [7:0]                        rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [irrc_pkg::PERIOD_WIDTH-1:0] csr_wr_data
);
   import irrc_pkg::*;

   logic [PERIOD_WIDTH-1:0] period_ff;
   logic                    accept, take;
   result_type              result;
   result_type              out_data_ff, skid_data_ff;
   logic                    out_valid_ff, skid_valid_ff;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   // sample period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= SAMPLE_PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   irrc_decoder #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .COMMAND_BITS (COMMAND_BITS)
   ) u_decoder (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .pin_level     (req_tdata[0]),
      .sample_period (period_ff),
      .result        (result)
   );

   // output register and skid valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   // output and skid payload
   always_ff @(posedge clock) begin
      if (take) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (accept) begin
            out_data_ff <= result;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_data_ff <= result;
         end else begin
            out_data_ff <= result;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_data_ff};

endmodule
